[rtl/ecap_pkg.sv]
package ecap_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int SECTIONS       = 3;
  localparam int LEN_W          = 16;
  localparam int OUT_W          = 32;
  localparam int CFG_IDX_W      = 2;

  localparam int SQRT_STEPS   = 37;
  localparam int RAD_W        = 74;
  localparam int REM_W        = 40;
  localparam int MOD_STAGES   = 3;
  localparam int MOD_W        = 38;
  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 59;
  localparam int ZW           = 34;

  localparam int SQRT_BASE  = 1;
  localparam int MOD_BASE   = SQRT_BASE + SQRT_STEPS;
  localparam int DIV_BASE   = MOD_BASE + MOD_STAGES;
  localparam int PIPE_DEPTH = DIV_BASE + DIV_STEPS;
  localparam int CLAMP_STG  = CORDIC_STEPS + 1;

  localparam logic [OUT_W-1:0] TWO_PI_Q29  = 32'd3373259426;
  localparam logic [ZW-1:0]    PI_Q29      = 34'd1686629713;
  localparam logic [ZW-1:0]    HALF_PI_Q29 = 34'd843314857;
  localparam logic [LEN_W-1:0] LEN_RESET   = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_THIRD  = 2'd2;

  function automatic logic [ZW-1:0] atan_q29(input int i);
    logic [ZW-1:0] v;
    case (i)
      0: v = 34'd421657428;
      1: v = 34'd248918915;
      2: v = 34'd131521918;
      3: v = 34'd66762579;
      4: v = 34'd33510843;
      5: v = 34'd16771758;
      6: v = 34'd8387925;
      7: v = 34'd4194219;
      8: v = 34'd2097141;
      9: v = 34'd1048575;
      default: v = (i < 30) ? (ZW'(1) << (29 - i)) : '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/exp_coord_to_arc_params.sv]
// Exponential coordinate to arc parameters, three robot sections.
// s_axis: one request per item, tdata holds six signed DATA_WIDTH fields.
// m_axis: one result per item, six 32-bit fields (curvature, plane angle).
// cfg: write cfg_we_i with cfg_idx_i 0..2 to set section lengths; other
//   indices are ignored. Write only while the pipeline is empty.
// The pipeline is the input squaring stage, 37-stage square root, 3-stage
//   2*pi reduction and 32-stage divider; the 30-step CORDIC runs alongside
//   and is delayed to match.
// Throughput: one item per cycle while m_axis_tready is high.
// Every stage has its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles are squeezed out under backpressure and
// s_axis_tready stays high while any stage is empty.
// Reset: pipeline emptied, lengths return to 100.
// On m_axis_tready low the result holds and the pipeline fills behind it.
module exp_coord_to_arc_params
  import ecap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // first_bend_x, first_bend_y, second_bend_x, second_bend_y,
  // third_bend_x, third_bend_y, zero pad
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // first_curvature, first_plane_angle, second_curvature,
  // second_plane_angle, third_curvature, third_plane_angle
  output logic [6*OUT_W-1:0]   m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i
);

  logic [LEN_W-1:0] len_q [SECTIONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SECTIONS; s++) begin
        len_q[s] <= LEN_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LENGTH_FIRST:  len_q[0] <= cfg_wdata_i;
        REG_LENGTH_SECOND: len_q[1] <= cfg_wdata_i;
        REG_LENGTH_THIRD:  len_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH:0]   rdy;
  logic [PIPE_DEPTH-1:0] adv;

  assign rdy[PIPE_DEPTH] = m_axis_tready;
  for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign adv = rdy[PIPE_DEPTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  for (genvar s = 0; s < SECTIONS; s++) begin : g_sec
    logic signed [DATA_WIDTH-1:0] bx, by;
    logic        [OUT_W-1:0]      curv, ang;
    assign bx = s_axis_tdata[(2*s)*DATA_WIDTH +: DATA_WIDTH];
    assign by = s_axis_tdata[(2*s+1)*DATA_WIDTH +: DATA_WIDTH];

    ecap_mag u_mag (
      .clk_i  (clk_i),
      .x_i    (bx),
      .y_i    (by),
      .len_i  (len_q[s]),
      .adv_i  (adv),
      .curv_o (curv)
    );

    ecap_cordic u_cordic (
      .clk_i   (clk_i),
      .x_i     (bx),
      .y_i     (by),
      .adv_i   (adv),
      .angle_o (ang)
    );

    assign m_axis_tdata[(2*s)*OUT_W +: OUT_W]   = curv;
    assign m_axis_tdata[(2*s+1)*OUT_W +: OUT_W] = ang;
  end

endmodule

[rtl/ecap_mag.sv]
module ecap_mag
  import ecap_pkg::*;
(
  input  logic                         clk_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] y_i,
  input  logic        [LEN_W-1:0]      len_i,
  input  logic        [PIPE_DEPTH-1:0] adv_i,
  output logic        [OUT_W-1:0]      curv_o
);

  logic [DATA_WIDTH-1:0] ax, ay;
  logic [63:0]           sq;

  assign ax = x_i[DATA_WIDTH-1] ? DATA_WIDTH'(-x_i) : DATA_WIDTH'(x_i);
  assign ay = y_i[DATA_WIDTH-1] ? DATA_WIDTH'(-y_i) : DATA_WIDTH'(y_i);
  assign sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);

  // digit-by-digit root, one result bit per stage
  logic [RAD_W-1:0]      rad_q  [SQRT_STEPS+1];
  logic [REM_W-1:0]      rem_q  [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0] root_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      rad_q[0]  <= {sq, 10'b0};
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [REM_W-1:0]      rem_sh, trial;
    logic [REM_W-1:0]      rem_d;
    logic [SQRT_STEPS-1:0] root_d;
    always_comb begin
      rem_sh = {rem_q[j][REM_W-3:0], rad_q[j][RAD_W-1 -: 2]};
      trial  = {1'b0, root_q[j], 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[j][SQRT_STEPS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[j][SQRT_STEPS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i[SQRT_BASE+j]) begin
        rad_q[j+1]  <= {rad_q[j][RAD_W-3:0], 2'b00};
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
      end
    end
  end

  // reduce modulo 2*pi, two conditional subtracts per stage
  logic [MOD_W-1:0] md_q [MOD_STAGES+1];

  assign md_q[0] = MOD_W'(root_q[SQRT_STEPS]);

  for (genvar m = 0; m < MOD_STAGES; m++) begin : g_mod
    localparam logic [MOD_W-1:0] T_HI = MOD_W'(TWO_PI_Q29) << (5 - 2 * m);
    localparam logic [MOD_W-1:0] T_LO = MOD_W'(TWO_PI_Q29) << (4 - 2 * m);
    logic [MOD_W-1:0] a1, a2;
    always_comb begin
      a1 = (md_q[m] >= T_HI) ? md_q[m] - T_HI : md_q[m];
      a2 = (a1 >= T_LO) ? a1 - T_LO : a1;
    end
    always_ff @(posedge clk_i) begin
      if (adv_i[MOD_BASE+m]) begin
        md_q[m+1] <= a2;
      end
    end
  end

  // restoring divide by section length
  logic [LEN_W-1:0] dvs;
  logic [OUT_W-1:0] da_q [DIV_STEPS+1];
  logic [LEN_W-1:0] dr_q [DIV_STEPS+1];

  assign dvs     = (len_i == '0) ? LEN_W'(1) : len_i;
  assign da_q[0] = md_q[MOD_STAGES][OUT_W-1:0];
  assign dr_q[0] = '0;

  for (genvar n = 0; n < DIV_STEPS; n++) begin : g_div
    logic [LEN_W:0]   t;
    logic [LEN_W-1:0] r_d;
    logic             qb;
    always_comb begin
      t = {dr_q[n], da_q[n][OUT_W-1]};
      if (t >= {1'b0, dvs}) begin
        r_d = LEN_W'(t - {1'b0, dvs});
        qb  = 1'b1;
      end else begin
        r_d = t[LEN_W-1:0];
        qb  = 1'b0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i[DIV_BASE+n]) begin
        da_q[n+1] <= {da_q[n][OUT_W-2:0], qb};
        dr_q[n+1] <= r_d;
      end
    end
  end

  assign curv_o = da_q[DIV_STEPS];

endmodule

[rtl/ecap_cordic.sv]
module ecap_cordic
  import ecap_pkg::*;
(
  input  logic                         clk_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] y_i,
  input  logic        [PIPE_DEPTH-1:0] adv_i,
  output logic        [OUT_W-1:0]      angle_o
);

  localparam int PRESCALE = 56 - DATA_WIDTH;
  localparam int DLY      = PIPE_DEPTH - 1 - CLAMP_STG;

  logic signed [CW-1:0] px, py, cx0, cy0;
  logic signed [ZW-1:0] z0;
  logic                 zero0;

  always_comb begin
    px    = CW'(y_i) <<< PRESCALE;
    py    = -(CW'(x_i) <<< PRESCALE);
    zero0 = (x_i == '0) && (y_i == '0);
    cx0   = px;
    cy0   = py;
    z0    = '0;
    if (px < 0) begin
      if (py >= 0) begin
        cx0 = py;
        cy0 = -px;
        z0  = HALF_PI_Q29;
      end else begin
        cx0 = -py;
        cy0 = px;
        z0  = -HALF_PI_Q29;
      end
    end
  end

  logic signed [CW-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q  [CORDIC_STEPS+1];
  logic                 zr_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      cx_q[0] <= cx0;
      cy_q[0] <= cy0;
      z_q[0]  <= z0;
      zr_q[0] <= zero0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = atan_q29(i);
    logic signed [CW-1:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv_i[i+1]) begin
        zr_q[i+1] <= zr_q[i];
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          z_q[i+1]  <= z_q[i] + ATAN;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          z_q[i+1]  <= z_q[i] - ATAN;
        end
      end
    end
  end

  logic signed [ZW-1:0] zf;
  logic        [OUT_W-1:0] ang_d;
  logic        [OUT_W-1:0] dly_q [DLY+1];

  always_comb begin
    zf = z_q[CORDIC_STEPS];
    if (zf > $signed(PI_Q29)) begin
      zf = PI_Q29;
    end else if (zf < -$signed(PI_Q29)) begin
      zf = -PI_Q29;
    end
    ang_d = zr_q[CORDIC_STEPS] ? '0 : zf[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[CLAMP_STG]) begin
      dly_q[0] <= ang_d;
    end
  end

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (adv_i[CLAMP_STG+1+k]) begin
        dly_q[k+1] <= dly_q[k];
      end
    end
  end

  assign angle_o = dly_q[DLY];

endmodule

[rtl/ecap_chk.sv]
module ecap_chk
  import ecap_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [((6*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [6*OUT_W-1:0]   m_axis_tdata,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [LEN_W-1:0]     cfg_wdata_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result during reset");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[31:0] < TWO_PI_Q29) &&
      (m_axis_tdata[95:64] < TWO_PI_Q29) &&
      (m_axis_tdata[159:128] < TWO_PI_Q29) &&
      ($signed(m_axis_tdata[63:32]) <= $signed(PI_Q29[31:0])) &&
      ($signed(m_axis_tdata[63:32]) >= -$signed(PI_Q29[31:0])) &&
      ($signed(m_axis_tdata[127:96]) <= $signed(PI_Q29[31:0])) &&
      ($signed(m_axis_tdata[127:96]) >= -$signed(PI_Q29[31:0])) &&
      ($signed(m_axis_tdata[191:160]) <= $signed(PI_Q29[31:0])) &&
      ($signed(m_axis_tdata[191:160]) >= -$signed(PI_Q29[31:0])))
    else $error("result field out of range");

endmodule

bind exp_coord_to_arc_params ecap_chk u_ecap_chk (.*);

[dv/arc_params_checker.sv]
`timescale 1ns / 100ps
module arc_params_checker
  import ecap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [6*32-1:0]      s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [6*OUT_W-1:0]   m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  logic [LEN_W-1:0]   sect_len [SECTIONS];
  logic [6*OUT_W-1:0] arc_q [$];

  localparam longint ATAN_TAB [30] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1};

  function automatic logic [31:0] bend_angle(longint x, longint y);
    longint cx, cy, z, t, dx, dy;
    cx = y <<< 24;
    cy = -x <<< 24;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy;
        cy = -t;
        z = 843314857;
      end else begin
        cx = -cy;
        cy = t;
        z = -843314857;
      end
    end
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx;
        cy -= dy;
        z += ATAN_TAB[i];
      end else begin
        cx -= dx;
        cy += dy;
        z -= ATAN_TAB[i];
      end
    end
    if (z > 1686629713) z = 1686629713;
    if (z < -1686629713) z = -1686629713;
    return z[31:0];
  endfunction

  function automatic logic [31:0] bend_curvature(longint x, longint y,
                                                 logic [LEN_W-1:0] len);
    logic [73:0] sq;
    logic [73:0] root, rem, trial;
    logic [37:0] wrapped;
    logic [63:0] ax, ay;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    sq = ({10'd0, ax * ax} + {10'd0, ay * ay}) << 10;
    root = '0;
    rem = '0;
    for (int k = 73; k >= 1; k -= 2) begin
      rem = (rem << 2) | {72'd0, sq[k], sq[k-1]};
      trial = (root << 2) | 74'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 74'd1;
      end else begin
        root = root << 1;
      end
    end
    wrapped = 38'(root % TWO_PI_Q29);
    return 32'(wrapped / ((len == 0) ? 38'd1 : 38'(len)));
  endfunction

  function automatic logic [6*OUT_W-1:0] arc_params(logic [6*32-1:0] coord);
    logic [6*OUT_W-1:0] r;
    longint x, y;
    for (int k = 0; k < SECTIONS; k++) begin
      x = longint'($signed(coord[64*k +: 32]));
      y = longint'($signed(coord[64*k+32 +: 32]));
      r[64*k +: 32] = bend_curvature(x, y, sect_len[k]);
      r[64*k+32 +: 32] = bend_angle(x, y);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [6*OUT_W-1:0] want;
    int bad;
    bad = 0;
    if (!rst_ni) begin
      for (int k = 0; k < SECTIONS; k++) sect_len[k] <= LEN_RESET;
      errors_o <= 0;
      arc_q.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i < SECTIONS) sect_len[cfg_idx_i] <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) arc_q.push_back(arc_params(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (arc_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          bad++;
        end else begin
          want = arc_q.pop_front();
          for (int f = 0; f < 6; f++)
            if (want[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[32*f +: 32], m_axis_tdata[32*f +: 32]);
              bad++;
            end
        end
      end
      errors_o <= errors_o + bad;
    end
  end

  assign pending_o = arc_q.size();

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import ecap_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [6*32-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [6*OUT_W-1:0]   m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [LEN_W-1:0]     cfg_wdata_i = '0;
  int                   errors, pending;
  longint               cycles = 0;
  int                   stall_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  exp_coord_to_arc_params i_dut (.*);

  arc_params_checker i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= (cycles % 16) < 5;
    endcase
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2);
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      4: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_coord(logic [6*32-1:0] coord);
    s_axis_tdata <= coord;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_len(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst(int count);
    int left;
    logic [6*32-1:0] c;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
        for (int f = 0; f < 6; f++) c[32*f +: 32] = rand_comp();
        send_coord(c);
        left--;
      end
      if ($urandom_range(0, 3) != 0) gap();
    end
  endtask

  logic [31:0] dvals [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                             32'h1, 32'h0100_0000, 32'hff00_0000, 32'h0648_7ed5};

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 2; j++)
        send_coord({dvals[(i+1)%8], dvals[i], dvals[(i+3)%8], dvals[i],
                    j ? 32'h0 : 32'hfff0_0000, dvals[i]});
    send_coord({32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0});
    send_coord({6{32'h0}});
    drain();
    write_len(REG_LENGTH_FIRST, 16'd1);
    write_len(REG_LENGTH_SECOND, 16'hffff);
    write_len(REG_LENGTH_THIRD, 16'd0);
    write_len(2'd3, 16'd7);
    random_burst(200);
    drain();
    write_len(REG_LENGTH_FIRST, 16'hffff);
    write_len(REG_LENGTH_SECOND, 16'd1);
    write_len(REG_LENGTH_THIRD, 16'd1);
    random_burst(200);
    drain();
    write_len(REG_LENGTH_FIRST, 16'($urandom_range(1, 65535)));
    write_len(REG_LENGTH_SECOND, 16'($urandom_range(1, 300)));
    write_len(REG_LENGTH_THIRD, 16'($urandom_range(1, 65535)));
    random_burst(200);
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[exp_coord_to_arc_params.f]
rtl/ecap_pkg.sv
rtl/ecap_mag.sv
rtl/ecap_cordic.sv
rtl/exp_coord_to_arc_params.sv
rtl/ecap_chk.sv
dv/arc_params_checker.sv
dv/testbench.sv
